FILE: sv/sdf_pkg.sv
// ----------------------------------------------------------------------------
// sdf_pkg: shared types and constants for the signed decimal formatter
// Sizes of the binary operand and BCD register, and the ASCII codes emitted.
// ----------------------------------------------------------------------------
package sdf_pkg;

    localparam int NUM_W         = 64;
    localparam int BCD_DIGITS    = 20;
    localparam int BCD_W         = 4 * BCD_DIGITS;
    localparam int BITS_PER_STEP = 4;
    localparam int CONV_STEPS    = NUM_W / BITS_PER_STEP;
    localparam int STEP_CNT_W    = $clog2(CONV_STEPS);
    localparam int DIGIT_CNT_W   = $clog2(BCD_DIGITS + 1);

    localparam logic [6:0] DIGIT_ZERO = 7'd48;
    localparam logic [6:0] MINUS_SIGN = 7'd45;

    typedef logic [BCD_W-1:0]         bcd_t;
    typedef logic [BITS_PER_STEP-1:0] chunk_t;

endpackage

FILE: sv/signed_decimal_formatter_core.sv
// Sequence: accept, conversion at 4 bits per cycle through the BCD step unit,
// a zero skip that drops leading zeros one at a time and then leaves,
// then one character per cycle while the output is not stalled.
// The block takes no new number until its last character is in the output register;
// the one shift-and-add-3 unit and the output register serve one item at a time.
// Reset (rst_n low, asynchronous) returns the sequencer to idle, output empty.
// ----------------------------------------------------------------------------
// signed_decimal_formatter_core: signed 64-bit integer to decimal ASCII text
// Converts the magnitude to BCD iteratively, then streams sign and digits.
// ----------------------------------------------------------------------------
module signed_decimal_formatter_core
    import sdf_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    in_valid,
    output logic                    in_ready,
    input  logic signed [NUM_W-1:0] number,
    output logic                    out_valid,
    input  logic                    out_ready,
    output logic [6:0]              character,
    output logic                    last_char
);

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_CONV  = 5'b00010,
        S_SKIP  = 5'b00100,
        S_SIGN  = 5'b01000,
        S_DIGIT = 5'b10000
    } state_t;

    state_t                  state_reg, state_next;
    logic [NUM_W-1:0]        bin_reg, bin_next;
    bcd_t                    bcd_reg, bcd_next;
    logic                    neg_reg, neg_next;
    logic [STEP_CNT_W-1:0]   step_reg, step_next;
    logic [DIGIT_CNT_W-1:0]  left_reg, left_next;
    logic                    ov_reg, ov_next;
    logic [6:0]              char_reg, char_next;
    logic                    last_reg, last_next;
    bcd_t                    bcd_step;
    logic                    slot_free;

    sdf_dabble u_dabble (
        .bcd_in  (bcd_reg),
        .bits_in (bin_reg[NUM_W-1 -: BITS_PER_STEP]),
        .bcd_out (bcd_step)
    );

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = ov_reg;
    assign character = char_reg;
    assign last_char = last_reg;
    assign slot_free = !ov_reg || out_ready;

    always_comb
    begin
        state_next = state_reg;
        bin_next   = bin_reg;
        bcd_next   = bcd_reg;
        neg_next   = neg_reg;
        step_next  = step_reg;
        left_next  = left_reg;
        ov_next    = ov_reg && !out_ready;
        char_next  = char_reg;
        last_next  = last_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    neg_next   = number[NUM_W-1];
                    bin_next   = number[NUM_W-1] ? (~number + 1'b1) : number;
                    bcd_next   = '0;
                    step_next  = '0;
                    state_next = S_CONV;
                end
            end
            S_CONV:
            begin
                bcd_next  = bcd_step;
                bin_next  = {bin_reg[NUM_W-BITS_PER_STEP-1:0], {BITS_PER_STEP{1'b0}}};
                step_next = step_reg + 1'b1;
                if (step_reg == STEP_CNT_W'(CONV_STEPS - 1))
                begin
                    left_next  = DIGIT_CNT_W'(BCD_DIGITS);
                    state_next = S_SKIP;
                end
            end
            S_SKIP:
            begin
                // drop leading zeros, keep at least one digit
                if (bcd_reg[BCD_W-1 -: 4] == 4'd0 && left_reg > DIGIT_CNT_W'(1))
                begin
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next = left_reg - 1'b1;
                end
                else
                begin
                    state_next = neg_reg ? S_SIGN : S_DIGIT;
                end
            end
            S_SIGN:
            begin
                if (slot_free)
                begin
                    ov_next    = 1'b1;
                    char_next  = MINUS_SIGN;
                    last_next  = 1'b0;
                    state_next = S_DIGIT;
                end
            end
            S_DIGIT:
            begin
                if (slot_free)
                begin
                    ov_next   = 1'b1;
                    char_next = DIGIT_ZERO + {3'b000, bcd_reg[BCD_W-1 -: 4]};
                    last_next = (left_reg == DIGIT_CNT_W'(1));
                    bcd_next  = {bcd_reg[BCD_W-5:0], 4'd0};
                    left_next = left_reg - 1'b1;
                    if (left_reg == DIGIT_CNT_W'(1))
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            ov_reg    <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            ov_reg    <= ov_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bin_reg  <= bin_next;
        bcd_reg  <= bcd_next;
        neg_reg  <= neg_next;
        step_reg <= step_next;
        left_reg <= left_next;
        char_reg <= char_next;
        last_reg <= last_next;
    end

endmodule

FILE: sv/sdf_dabble.sv
// ----------------------------------------------------------------------------
// sdf_dabble: shift-and-add-3 step of the binary to BCD converter
// Folds four binary bits, MSB first, into a 20-digit BCD accumulator.
// ----------------------------------------------------------------------------
module sdf_dabble
    import sdf_pkg::*;
(
    input  bcd_t   bcd_in,
    input  chunk_t bits_in,
    output bcd_t   bcd_out
);

    always_comb
    begin
        bcd_t acc;
        acc = bcd_in;
        for (int b = BITS_PER_STEP - 1; b >= 0; b--)
        begin
            // adjust any digit of five or more before it doubles
            for (int d = 0; d < BCD_DIGITS; d++)
            begin
                if (acc[4*d +: 4] >= 4'd5)
                begin
                    acc[4*d +: 4] = acc[4*d +: 4] + 4'd3;
                end
            end
            acc = {acc[BCD_W-2:0], bits_in[b]};
        end
        bcd_out = acc;
    end

endmodule

FILE: tb/tb_signed_decimal_formatter_core.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_decimal_formatter_core: self-checking bench for the decimal formatter
// Feeds signed 64-bit numbers through a valid/ready source, predicts the ASCII
// text of each, and compares every output transaction with the oldest expected
// character, under several patterns of source idling and sink back-pressure.
// ----------------------------------------------------------------------------
module tb_signed_decimal_formatter_core;
    import sdf_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 60;
    localparam int RAND_ITEMS  = 260;
    localparam int DIR_N       = 22;
    localparam int PHASE_N     = 4;

    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } text_char_t;

    logic                    clk;
    logic                    rst_n     = 1'b0;
    logic                    in_valid  = 1'b0;
    logic                    in_ready;
    logic signed [NUM_W-1:0] number    = '0;
    logic                    out_valid;
    logic                    out_ready = 1'b0;
    logic [6:0]              character;
    logic                    last_char;

    text_char_t text_q[$];
    int         mismatches  = 0;
    int         cycles      = 0;
    int         src_idle_pct  = 0;
    int         sink_stall_pct = 0;

    // directed numbers; an empty text means the predictor supplies the result
    logic signed [NUM_W-1:0] dir_num [0:DIR_N-1] = '{
        64'sd0,
        64'sd1,
        -64'sd1,
        64'sd9,
        64'sd10,
        -64'sd10,
        64'sd99,
        64'sd100,
        -64'sd5,
        64'sh7FFF_FFFF_FFFF_FFFF,
        64'sh8000_0000_0000_0000,
        64'sh8000_0000_0000_0001,
        64'sh7FFF_FFFF_FFFF_FFFE,
        64'sd1000000000000000000,
        64'sd999999999999999999,
        -64'sd999999999999999999,
        64'sd1234567890123456789,
        64'sh5555_5555_5555_5555,
        64'shAAAA_AAAA_AAAA_AAAA,
        64'sd42,
        -64'sd1000000000000000000,
        64'sh0000_0001_0000_0000
    };
    string dir_text [0:DIR_N-1] = '{
        "0",
        "1",
        "-1",
        "9",
        "10",
        "-10",
        "99",
        "100",
        "-5",
        "9223372036854775807",
        "-9223372036854775808",
        "",
        "",
        "1000000000000000000",
        "999999999999999999",
        "-999999999999999999",
        "",
        "",
        "",
        "",
        "-1000000000000000000",
        ""
    };

    int phase_src_idle  [0:PHASE_N-1] = '{0, 76, 0, 25};
    int phase_sink_stall[0:PHASE_N-1] = '{0, 0, 76, 25};

    signed_decimal_formatter_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .number    (number),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .character (character),
        .last_char (last_char)
    );

    always
    begin
        clk = 1'b1;
        #4;
        clk = 1'b0;
        #4;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        out_ready <= ($urandom_range(99) >= sink_stall_pct);
    end

    // decimal text of a signed value: sign, then digits with no leading zeros
    function automatic void predict_text(input logic signed [NUM_W-1:0] value);
        logic [NUM_W-1:0] raw;
        logic [NUM_W-1:0] mag;
        logic [3:0]       digs [0:BCD_DIGITS-1];
        int               n;
        raw = value;
        mag = raw[NUM_W-1] ? -raw : raw;
        n = 0;
        do
        begin
            digs[n] = 4'(mag % 64'd10);
            n++;
            mag = mag / 64'd10;
        end
        while (mag != 0);
        if (raw[NUM_W-1])
            text_q.push_back('{MINUS_SIGN, 1'b0});
        for (int k = n - 1; k >= 0; k--)
            text_q.push_back('{DIGIT_ZERO + 7'(digs[k]), k == 0});
    endfunction

    function automatic void push_literal_text(input string s);
        for (int i = 0; i < s.len(); i++)
            text_q.push_back('{s[i][6:0], i == s.len() - 1});
    endfunction

    function automatic logic signed [NUM_W-1:0] pick_number();
        logic [NUM_W-1:0] v;
        int               p;
        case ($urandom_range(9))
            0, 1, 2, 3:
                v = {$urandom, $urandom};
            4, 5:
                v = 64'($urandom_range(0, 999));
            6:
            begin
                // powers of ten and their neighbors exercise digit-count edges
                p = $urandom_range(0, 18);
                v = 64'd1;
                repeat (p) v = v * 64'd10;
                v = v + 64'($urandom_range(0, 2)) - 64'd1;
            end
            7:
                v = $urandom_range(1) ? 64'h7FFF_FFFF_FFFF_FFFF - 64'($urandom_range(0, 3))
                                      : 64'h8000_0000_0000_0000 + 64'($urandom_range(0, 3));
            default:
                v = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        if ($urandom_range(1))
            v = -v;
        return v;
    endfunction

    // present one number, hold it until the transaction, then log its text
    task automatic send_number(input logic signed [NUM_W-1:0] value, input string text);
        if ($urandom_range(99) < src_idle_pct)
        begin
            in_valid <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < src_idle_pct);
        end
        in_valid <= 1'b1;
        number   <= value;
        do
            @(posedge clk);
        while (!in_ready);
        if (text.len() != 0)
            push_literal_text(text);
        else
            predict_text(value);
    endtask

    always @(posedge clk)
    begin : check_output
        text_char_t want;
        if (rst_n && out_valid && out_ready)
        begin
            if (text_q.size() == 0)
            begin
                $error("unexpected character: got %0d last %0b", character, last_char);
                mismatches++;
            end
            else
            begin
                want = text_q.pop_front();
                if (character !== want.ch)
                begin
                    $error("character: expected %0d, actual %0d", want.ch, character);
                    mismatches++;
                end
                if (last_char !== want.last)
                begin
                    $error("last_char: expected %0b, actual %0b", want.last, last_char);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        for (int i = 0; i < DIR_N; i++)
            send_number(dir_num[i], dir_text[i]);

        for (int p = 0; p < PHASE_N; p++)
        begin
            src_idle_pct   = phase_src_idle[p];
            sink_stall_pct = phase_sink_stall[p];
            for (int i = 0; i < RAND_ITEMS / PHASE_N; i++)
                send_number(pick_number(), "");
        end
        in_valid <= 1'b0;

        while (text_q.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatches == 0 && text_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
